[src/olpd_pkg.sv]
// olpd_pkg: shared types and codes for the ordered list push/pop/delete unit.
// Used by olpd_ctrl, olpd_dp and ordered_list_push_pop_delete_unit; no dependencies.
`timescale 1ns / 1ps

package olpd_pkg;

  // request codes on req_type
  typedef enum logic [1:0] {
    REQ_PUSH   = 2'd0,
    REQ_POP    = 2'd1,
    REQ_DELETE = 2'd2
  } req_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_NOTHING = 2'd1,
    ST_FULL    = 2'd2
  } stat_e;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_POP_WAIT,
    S_SHIFT
  } state_e;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_PUSH,
    OP_POP_READ,
    OP_POP_REPLY,
    OP_DEL_SINGLE,
    OP_DEL_FIRST,
    OP_SHIFT,
    OP_SHIFT_LAST,
    OP_REPLY_NOTHING,
    OP_REPLY_FULL
  } op_e;

  // controller -> datapath
  typedef struct packed {
    op_e op;
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] req;
    logic       full;
    logic       empty;
    logic       del_ok;
    logic       del_last;
    logic       shift_more;
  } dp_stat_t;

endpackage

[src/olpd_ctrl.sv]
// olpd_ctrl: request sequencer for the ordered list unit.
// Depends on olpd_pkg; drives olpd_dp through ctl_t and reads dp_stat_t.
`timescale 1ns / 1ps

module olpd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  olpd_pkg::dp_stat_t stat_i,
  output olpd_pkg::ctl_t    ctl_o,
  output logic              busy_o
);
  import olpd_pkg::*;

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_IDLE;
        case (stat_i.req)
          REQ_POP: begin
            if (!stat_i.empty) state_d = S_POP_WAIT;
          end
          REQ_DELETE: begin
            if (stat_i.del_ok && !stat_i.del_last) state_d = S_SHIFT;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_POP_WAIT: state_d = S_IDLE;
      S_SHIFT: begin
        if (!stat_i.shift_more) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctl_o.op = OP_NONE;
    busy_o   = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        busy_o = 1'b0;
        if (start_i) ctl_o.op = OP_LOAD;
      end
      S_EXEC: begin
        case (stat_i.req)
          REQ_PUSH:   ctl_o.op = stat_i.full ? OP_REPLY_FULL : OP_PUSH;
          REQ_POP:    ctl_o.op = stat_i.empty ? OP_REPLY_NOTHING : OP_POP_READ;
          REQ_DELETE: begin
            if (!stat_i.del_ok) begin
              ctl_o.op = OP_REPLY_NOTHING;
            end else if (stat_i.del_last) begin
              ctl_o.op = OP_DEL_SINGLE;
            end else begin
              ctl_o.op = OP_DEL_FIRST;
            end
          end
          default: ctl_o.op = OP_REPLY_NOTHING;
        endcase
      end
      S_POP_WAIT: ctl_o.op = OP_POP_REPLY;
      S_SHIFT:    ctl_o.op = stat_i.shift_more ? OP_SHIFT : OP_SHIFT_LAST;
      default:    ctl_o.op = OP_NONE;
    endcase
  end

endmodule

[src/olpd_dp.sv]
// olpd_dp: entry store, count and result registers of the ordered list unit.
// Depends on olpd_pkg; sequenced by olpd_ctrl.
`timescale 1ns / 1ps

module olpd_dp #(
  parameter int CAPACITY = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  olpd_pkg::ctl_t     ctl_i,
  input  logic [1:0]         req_type_i,
  input  logic signed [31:0] push_value_i,
  input  logic [5:0]         position_i,
  output olpd_pkg::dp_stat_t stat_o,
  output logic               done_o,
  output logic signed [31:0] popped_value_o,
  output logic [1:0]         status_o,
  output logic [6:0]         entry_count_o
);
  import olpd_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = CW + 6;

  // entry store, registered read
  logic [31:0] mem_q [CAPACITY];
  logic [31:0] rdata_q;

  // request registers
  logic [1:0]         req_q;
  logic signed [31:0] val_q;
  logic [5:0]         pos_q;

  // list state
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] idx_q, idx_d;

  // result registers
  logic               done_q, done_d;
  logic signed [31:0] popped_q, popped_d;
  stat_e              status_q, status_d;

  // derived values
  logic [EW-1:0] pos_ext, pos_p1, count_ext, idx_ext;
  logic [CW-1:0] cnt_m1;
  logic [AW-1:0] idx_p1, idx_p2;
  logic          wr_en, rd_en;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata;
  logic [CW+6:0] cnt_wide;

  assign pos_ext   = EW'(pos_q);
  assign pos_p1    = pos_ext + EW'(1);
  assign count_ext = EW'(count_q);
  assign idx_ext   = EW'(idx_q);
  assign cnt_m1    = count_q - CW'(1);
  assign idx_p1    = idx_q + AW'(1);
  assign idx_p2    = idx_q + AW'(2);

  // status to controller
  assign stat_o.req        = req_q;
  assign stat_o.full       = (count_q == CW'(CAPACITY));
  assign stat_o.empty      = (count_q == '0);
  assign stat_o.del_ok     = (pos_ext < count_ext);
  assign stat_o.del_last   = (pos_p1 == count_ext);
  assign stat_o.shift_more = ((idx_ext + EW'(2)) < count_ext);

  // operation decode
  always_comb begin
    count_d  = count_q;
    idx_d    = idx_q;
    done_d   = 1'b0;
    popped_d = popped_q;
    status_d = status_q;
    wr_en    = 1'b0;
    waddr    = idx_q;
    wdata    = rdata_q;
    rd_en    = 1'b0;
    raddr    = idx_p2;
    unique case (ctl_i.op)
      OP_PUSH: begin
        wr_en    = 1'b1;
        waddr    = count_q[AW-1:0];
        wdata    = val_q;
        count_d  = count_q + CW'(1);
        done_d   = 1'b1;
        popped_d = '0;
        status_d = ST_DONE;
      end
      OP_POP_READ: begin
        rd_en   = 1'b1;
        raddr   = cnt_m1[AW-1:0];
        count_d = cnt_m1;
      end
      OP_POP_REPLY: begin
        done_d   = 1'b1;
        popped_d = rdata_q;
        status_d = ST_DONE;
      end
      OP_DEL_SINGLE: begin
        count_d  = cnt_m1;
        done_d   = 1'b1;
        popped_d = '0;
        status_d = ST_DONE;
      end
      OP_DEL_FIRST: begin
        rd_en = 1'b1;
        raddr = pos_p1[AW-1:0];
        idx_d = pos_ext[AW-1:0];
      end
      OP_SHIFT: begin
        wr_en = 1'b1;
        rd_en = 1'b1;
        idx_d = idx_p1;
      end
      OP_SHIFT_LAST: begin
        wr_en    = 1'b1;
        count_d  = cnt_m1;
        done_d   = 1'b1;
        popped_d = '0;
        status_d = ST_DONE;
      end
      OP_REPLY_NOTHING: begin
        done_d   = 1'b1;
        popped_d = '0;
        status_d = ST_NOTHING;
      end
      OP_REPLY_FULL: begin
        done_d   = 1'b1;
        popped_d = '0;
        status_d = ST_FULL;
      end
      default: ;
    endcase
  end

  // store write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[waddr] <= wdata;
    if (rd_en) rdata_q <= mem_q[raddr];
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (ctl_i.op == OP_LOAD) begin
      req_q <= req_type_i;
      val_q <= push_value_i;
      pos_q <= position_i;
    end
  end

  // shift index and result payload
  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    popped_q <= popped_d;
    status_q <= status_d;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  // outputs; the count port carries the low seven bits
  assign cnt_wide       = {7'b0, count_q};
  assign done_o         = done_q;
  assign popped_value_o = popped_q;
  assign status_o       = status_q;
  assign entry_count_o  = cnt_wide[6:0];

endmodule

[src/ordered_list_push_pop_delete_unit.sv]
// Ordered list push/pop/delete unit: top level joining olpd_ctrl and olpd_dp.
// Depends on olpd_pkg, olpd_ctrl and olpd_dp.
`timescale 1ns / 1ps

// A request word is taken when start_i is high and busy_o is low; exactly one
// result word follows, shown for a single cycle with done_o high, and the
// receiver cannot stall it. A push, a failed pop or push, a delete out of
// range, the unused request code and a delete of the tail entry are answered
// straight from the execute state; a successful pop first makes one
// registered read of the store. Deleting position p from a list moves the
// entries above p down one per cycle, each read from the store and written
// back one place lower. busy_o drops in the cycle done_o is shown, so a new
// request may be taken then. entry_count_o is the list size, valid with
// done_o. The store needs no clearing after reset.
module ordered_list_push_pop_delete_unit #(
  parameter int CAPACITY = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         req_type_i,
  input  logic signed [31:0] push_value_i,
  input  logic [5:0]         position_i,
  output logic               done_o,
  output logic signed [31:0] popped_value_o,
  output logic [1:0]         status_o,
  output logic [6:0]         entry_count_o
);
  import olpd_pkg::*;

  ctl_t     ctl;
  dp_stat_t stat;

  // sequencer
  olpd_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .ctl_o   (ctl),
    .busy_o  (busy_o)
  );

  // store and result registers
  olpd_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .req_type_i     (req_type_i),
    .push_value_i   (push_value_i),
    .position_i     (position_i),
    .stat_o         (stat),
    .done_o         (done_o),
    .popped_value_o (popped_value_o),
    .status_o       (status_o),
    .entry_count_o  (entry_count_o)
  );

`ifndef SYNTHESIS
  // a result is shown for one cycle only
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("done_o held for more than one cycle");

  // an accepted word keeps the unit busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("busy_o not raised after accept");

  // a result comes only once the unit is free again
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("done_o while busy");

  // only a successful pop returns a value
  a_popped_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_DONE) |-> (popped_value_o == '0))
    else $error("nonzero popped value on failed request");
`endif

endmodule
